@@ src/rptp_pkg.sv @@
// Shared types and constants of the ray/plane tile pick core.
package rptp_pkg;

    localparam int MAX_TILES  = 1024;
    localparam int TILE_BITS  = 10;
    localparam int DIV_STEPS  = 34;
    localparam int CFG_IDX_W  = 8;
    localparam int PAR_BOUND  = 1 << 20;

    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_X     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Y     = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_Z     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_OFFSET = 8'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH   = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_LENGTH  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH   = 8'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_LENGTH  = 8'd7;

    localparam logic [31:0] REJ_POINT = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        CAUSE_HIT       = 2'd0,
        CAUSE_PARALLEL  = 2'd1,
        CAUSE_T_NOT_POS = 2'd2,
        CAUSE_OUTSIDE   = 2'd3
    } rptp_cause_t;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] start_z;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic signed [31:0] end_z;
    } rptp_in_t;

    typedef struct packed {
        logic               hit;
        logic [1:0]         reject_cause;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [9:0]         tile_column;
        logic [9:0]         tile_row;
    } rptp_out_t;

endpackage

@@ src/ray_plane_tile_pick_core.sv @@
// Top level: pipelined pick segment / plane intersection with tile lookup.
//
// Usage
//   s_valid/s_ready/s_data carry one pick segment (start and end point, Q16.16)
//   per transaction; m_valid/m_ready/m_data return one result per segment, in
//   order: hit flag, reject cause, intersection point and tile column/row.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the plane and map registers;
//   cfg_ready is always high, an index past the register list is ignored.
//   Write configuration only while no segment is in flight.
// Timing
//   One segment per cycle is taken in steady state while the output is not
//   stalled. The pipeline holds the 34-step restoring divider (one quotient
//   bit per stage) for the point offset, followed by the 10-step tile index
//   divider.
// Reset and stall
//   Synchronous reset (aresetn low) empties the pipeline and loads the
//   register defaults. When the receiver stalls, one result parks in a skid
//   register; the pipeline then freezes and s_ready drops until it drains.
module ray_plane_tile_pick_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  rptp_pkg::rptp_in_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output rptp_pkg::rptp_out_t           m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [rptp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import rptp_pkg::*;

    // divider stage: remainder, remaining dividend bits, quotient so far
    typedef struct packed {
        rptp_cause_t             cause;
        logic [2:0][31:0]        s;
        logic [2:0]              dneg;
        logic [2:0]              cap;
        logic [50:0]             aden;
        logic [2:0][50:0]        rem;
        logic [2:0][33:0]        lo;
        logic [2:0][33:0]        q;
    } dv_t;

    // tile index stage
    typedef struct packed {
        rptp_cause_t  cause;
        logic [31:0]  px;
        logic [31:0]  py;
        logic [31:0]  pz;
        logic         capx;
        logic         capz;
        logic [30:0]  remx;
        logic [30:0]  remz;
        logic [9:0]   lox;
        logic [9:0]   loz;
        logic [9:0]   qx;
        logic [9:0]   qz;
    } tl_t;

    localparam logic signed [51:0] PAR_HI = 52'(PAR_BOUND);
    localparam logic signed [51:0] PAR_LO = -52'(PAR_BOUND);

    // ---------------- configuration registers ----------------
    logic signed [17:0] normal_x_reg, normal_y_reg, normal_z_reg;
    logic signed [31:0] plane_offset_reg;
    logic [30:0]        half_width_reg, half_length_reg;
    logic [30:0]        tile_width_reg, tile_length_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            normal_x_reg     <= 18'sd0;
            normal_y_reg     <= 18'sd65536;
            normal_z_reg     <= 18'sd0;
            plane_offset_reg <= 32'sd0;
            half_width_reg   <= 31'd196608;
            half_length_reg  <= 31'd196608;
            tile_width_reg   <= 31'd65536;
            tile_length_reg  <= 31'd65536;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_NORMAL_X:     normal_x_reg     <= cfg_data[17:0];
                REG_NORMAL_Y:     normal_y_reg     <= cfg_data[17:0];
                REG_NORMAL_Z:     normal_z_reg     <= cfg_data[17:0];
                REG_PLANE_OFFSET: plane_offset_reg <= cfg_data;
                REG_HALF_WIDTH:   half_width_reg   <= cfg_data[30:0];
                REG_HALF_LENGTH:  half_length_reg  <= cfg_data[30:0];
                REG_TILE_WIDTH:   tile_width_reg   <= cfg_data[30:0];
                REG_TILE_LENGTH:  tile_length_reg  <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // ---------------- flow control ----------------
    logic en;              // whole pipeline advances
    logic skid_valid_reg;
    assign en      = !skid_valid_reg;
    assign s_ready = en;

    logic signed [17:0] nrm [3];
    assign nrm[0] = normal_x_reg;
    assign nrm[1] = normal_y_reg;
    assign nrm[2] = normal_z_reg;

    // ---------------- stage A: input register ----------------
    logic     va_reg;
    rptp_in_t in_reg;

    // ---------------- stage B: direction ----------------
    logic               vb_reg;
    logic signed [31:0] s_b_reg [3];
    logic signed [32:0] d_b_reg [3];
    logic signed [31:0] s_a [3];
    logic signed [31:0] e_a [3];

    assign s_a[0] = in_reg.start_x;
    assign s_a[1] = in_reg.start_y;
    assign s_a[2] = in_reg.start_z;
    assign e_a[0] = in_reg.end_x;
    assign e_a[1] = in_reg.end_y;
    assign e_a[2] = in_reg.end_z;

    // ---------------- stage C: products with the normal ----------------
    logic               vc_reg;
    logic signed [31:0] s_c_reg [3];
    logic signed [32:0] d_c_reg [3];
    logic signed [50:0] nd_c_reg [3];
    logic signed [49:0] ns_c_reg [3];

    // ---------------- stage D: dot products ----------------
    logic               vd_reg;
    logic signed [31:0] s_d_reg [3];
    logic signed [32:0] d_d_reg [3];
    logic signed [51:0] den_d_reg;
    logic signed [50:0] num_d_reg;
    logic signed [51:0] den_d_next;
    logic signed [50:0] num_d_next;

    always_comb begin
        den_d_next = 52'(nd_c_reg[0]) + 52'(nd_c_reg[1]) + 52'(nd_c_reg[2]);
        num_d_next = 51'($signed({plane_offset_reg, 16'b0}))
                   - 51'(ns_c_reg[0]) - 51'(ns_c_reg[1]) - 51'(ns_c_reg[2]);
    end

    // ---------------- stage E: classify, magnitudes ----------------
    logic        ve_reg;
    rptp_cause_t cause_e_reg;
    logic [31:0] s_e_reg [3];
    logic [31:0] ad_e_reg [3];
    logic [2:0]  dneg_e_reg;
    logic [50:0] aden_e_reg;
    logic [49:0] anum_e_reg;
    rptp_cause_t cause_e_next;

    always_comb begin
        if (den_d_reg <= PAR_HI && den_d_reg >= PAR_LO) begin
            cause_e_next = CAUSE_PARALLEL;
        end else if (num_d_reg == '0 || (num_d_reg[50] != den_d_reg[51])) begin
            cause_e_next = CAUSE_T_NOT_POS;
        end else begin
            cause_e_next = CAUSE_HIT;
        end
    end

    // ---------------- stage F: split products |d|*|num| ----------------
    logic        vf_reg;
    rptp_cause_t cause_f_reg;
    logic [31:0] s_f_reg [3];
    logic [2:0]  dneg_f_reg;
    logic [50:0] aden_f_reg;
    logic [56:0] pl_f_reg [3];
    logic [56:0] ph_f_reg [3];

    // ---------------- stage G: full product ----------------
    logic        vg_reg;
    rptp_cause_t cause_g_reg;
    logic [31:0] s_g_reg [3];
    logic [2:0]  dneg_g_reg;
    logic [50:0] aden_g_reg;
    logic [81:0] prod_g_reg [3];

    // ---------------- divider ----------------
    logic dv_v_reg [0:DIV_STEPS];
    dv_t  dv_reg   [0:DIV_STEPS];
    dv_t  dv_next  [0:DIV_STEPS-1];
    dv_t  dv_init;

    always_comb begin
        dv_init.cause = cause_g_reg;
        dv_init.dneg  = dneg_g_reg;
        dv_init.aden  = aden_g_reg;
        for (int c = 0; c < 3; c++) begin
            dv_init.s[c]   = s_g_reg[c];
            // quotient of 2^34 or more is capped: point then lies off any map
            dv_init.cap[c] = {3'b0, prod_g_reg[c]} >= {aden_g_reg, 34'b0};
            dv_init.rem[c] = {3'b0, prod_g_reg[c][81:34]};
            dv_init.lo[c]  = prod_g_reg[c][33:0];
            dv_init.q[c]   = '0;
        end
    end

    always_comb begin
        for (int k = 0; k < DIV_STEPS; k++) begin
            dv_next[k] = dv_reg[k];
            for (int c = 0; c < 3; c++) begin
                logic [51:0] r2;
                r2 = {dv_reg[k].rem[c], dv_reg[k].lo[c][33]};
                dv_next[k].lo[c] = {dv_reg[k].lo[c][32:0], 1'b0};
                if (r2 >= {1'b0, dv_reg[k].aden}) begin
                    dv_next[k].rem[c] = 51'(r2 - {1'b0, dv_reg[k].aden});
                    dv_next[k].q[c]   = {dv_reg[k].q[c][32:0], 1'b1};
                end else begin
                    dv_next[k].rem[c] = r2[50:0];
                    dv_next[k].q[c]   = {dv_reg[k].q[c][32:0], 1'b0};
                end
            end
        end
    end

    // ---------------- stage P: point, rectangle test, tile setup ----------------
    logic tl_v_reg [0:TILE_BITS];
    tl_t  tl_reg   [0:TILE_BITS];
    tl_t  tl_next  [0:TILE_BITS-1];
    tl_t  tl_init;

    always_comb begin
        logic signed [36:0] p [3];
        logic signed [36:0] hw, hl;
        logic [32:0]        shx, shz;
        dv_t                d;
        d  = dv_reg[DIV_STEPS];
        hw = $signed({6'b0, half_width_reg});
        hl = $signed({6'b0, half_length_reg});
        for (int c = 0; c < 3; c++) begin
            logic [36:0] qq;
            logic signed [36:0] ps;
            qq = d.cap[c] ? 37'(64'd1 << DIV_STEPS) : {3'b0, d.q[c]};
            ps = {{5{d.s[c][31]}}, d.s[c]};
            p[c] = d.dneg[c] ? ps - $signed(qq) : ps + $signed(qq);
        end
        tl_init.cause = d.cause;
        if (d.cause == CAUSE_HIT &&
            (p[0] < -hw || p[0] > hw || p[2] < -hl || p[2] > hl)) begin
            tl_init.cause = CAUSE_OUTSIDE;
        end
        tl_init.px = p[0][31:0];
        tl_init.pz = p[2][31:0];
        // y is free to leave the int32 range: saturate
        if (p[1] > 37'sh0_7FFF_FFFF) begin
            tl_init.py = 32'h7FFF_FFFF;
        end else if (p[1] < -37'sh0_8000_0000) begin
            tl_init.py = 32'h8000_0000;
        end else begin
            tl_init.py = p[1][31:0];
        end
        shx = 33'(p[0] + hw);
        shz = 33'(p[2] + hl);
        // zero tile size always caps
        tl_init.capx = {8'b0, shx} >= {tile_width_reg, 10'b0};
        tl_init.capz = {8'b0, shz} >= {tile_length_reg, 10'b0};
        tl_init.remx = {8'b0, shx[32:10]};
        tl_init.remz = {8'b0, shz[32:10]};
        tl_init.lox  = shx[9:0];
        tl_init.loz  = shz[9:0];
        tl_init.qx   = '0;
        tl_init.qz   = '0;
    end

    always_comb begin
        for (int k = 0; k < TILE_BITS; k++) begin
            logic [31:0] rx, rz;
            tl_next[k] = tl_reg[k];
            rx = {tl_reg[k].remx, tl_reg[k].lox[9]};
            rz = {tl_reg[k].remz, tl_reg[k].loz[9]};
            tl_next[k].lox = {tl_reg[k].lox[8:0], 1'b0};
            tl_next[k].loz = {tl_reg[k].loz[8:0], 1'b0};
            if (rx >= {1'b0, tile_width_reg}) begin
                tl_next[k].remx = 31'(rx - {1'b0, tile_width_reg});
                tl_next[k].qx   = {tl_reg[k].qx[8:0], 1'b1};
            end else begin
                tl_next[k].remx = rx[30:0];
                tl_next[k].qx   = {tl_reg[k].qx[8:0], 1'b0};
            end
            if (rz >= {1'b0, tile_length_reg}) begin
                tl_next[k].remz = 31'(rz - {1'b0, tile_length_reg});
                tl_next[k].qz   = {tl_reg[k].qz[8:0], 1'b1};
            end else begin
                tl_next[k].remz = rz[30:0];
                tl_next[k].qz   = {tl_reg[k].qz[8:0], 1'b0};
            end
        end
    end

    // ---------------- result formatting ----------------
    rptp_out_t res;
    tl_t       tf;
    assign tf = tl_reg[TILE_BITS];

    always_comb begin
        res.reject_cause = tf.cause;
        if (tf.cause == CAUSE_HIT) begin
            res.hit         = 1'b1;
            res.point_x     = tf.px;
            res.point_y     = tf.py;
            res.point_z     = tf.pz;
            res.tile_column = tf.capx ? 10'(MAX_TILES - 1) : tf.qx;
            res.tile_row    = tf.capz ? 10'(MAX_TILES - 1) : tf.qz;
        end else begin
            res.hit         = 1'b0;
            res.point_x     = REJ_POINT;
            res.point_y     = REJ_POINT;
            res.point_z     = REJ_POINT;
            res.tile_column = '0;
            res.tile_row    = '0;
        end
    end

    // ---------------- pipeline valid bits ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
            for (int k = 0; k <= DIV_STEPS; k++) dv_v_reg[k] <= 1'b0;
            for (int k = 0; k <= TILE_BITS; k++) tl_v_reg[k] <= 1'b0;
        end else if (en) begin
            va_reg      <= s_valid;
            vb_reg      <= va_reg;
            vc_reg      <= vb_reg;
            vd_reg      <= vc_reg;
            ve_reg      <= vd_reg;
            vf_reg      <= ve_reg;
            vg_reg      <= vf_reg;
            dv_v_reg[0] <= vg_reg;
            for (int k = 1; k <= DIV_STEPS; k++) dv_v_reg[k] <= dv_v_reg[k-1];
            tl_v_reg[0] <= dv_v_reg[DIV_STEPS];
            for (int k = 1; k <= TILE_BITS; k++) tl_v_reg[k] <= tl_v_reg[k-1];
        end
    end

    // ---------------- pipeline payload ----------------
    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= s_data;
            for (int c = 0; c < 3; c++) begin
                s_b_reg[c]  <= s_a[c];
                d_b_reg[c]  <= $signed({e_a[c][31], e_a[c]}) - $signed({s_a[c][31], s_a[c]});

                s_c_reg[c]  <= s_b_reg[c];
                d_c_reg[c]  <= d_b_reg[c];
                nd_c_reg[c] <= nrm[c] * d_b_reg[c];
                ns_c_reg[c] <= nrm[c] * s_b_reg[c];

                s_d_reg[c]  <= s_c_reg[c];
                d_d_reg[c]  <= d_c_reg[c];

                s_e_reg[c]    <= s_d_reg[c];
                dneg_e_reg[c] <= d_d_reg[c][32];
                ad_e_reg[c]   <= d_d_reg[c][32] ? 32'(-d_d_reg[c]) : d_d_reg[c][31:0];

                s_f_reg[c]  <= s_e_reg[c];
                pl_f_reg[c] <= 57'(ad_e_reg[c]) * 57'(anum_e_reg[24:0]);
                ph_f_reg[c] <= 57'(ad_e_reg[c]) * 57'(anum_e_reg[49:25]);

                s_g_reg[c]    <= s_f_reg[c];
                prod_g_reg[c] <= 82'(pl_f_reg[c]) + {ph_f_reg[c], 25'b0};
            end
            den_d_reg   <= den_d_next;
            num_d_reg   <= num_d_next;

            cause_e_reg <= cause_e_next;
            aden_e_reg  <= den_d_reg[51] ? 51'(-den_d_reg) : den_d_reg[50:0];
            anum_e_reg  <= num_d_reg[50] ? 50'(-num_d_reg) : num_d_reg[49:0];

            cause_f_reg <= cause_e_reg;
            dneg_f_reg  <= dneg_e_reg;
            aden_f_reg  <= aden_e_reg;

            cause_g_reg <= cause_f_reg;
            dneg_g_reg  <= dneg_f_reg;
            aden_g_reg  <= aden_f_reg;

            dv_reg[0] <= dv_init;
            for (int k = 1; k <= DIV_STEPS; k++) dv_reg[k] <= dv_next[k-1];
            tl_reg[0] <= tl_init;
            for (int k = 1; k <= TILE_BITS; k++) tl_reg[k] <= tl_next[k-1];
        end
    end

    // ---------------- output register and skid ----------------
    logic      out_valid_reg;
    rptp_out_t out_reg;
    rptp_out_t skid_reg;
    logic      push;
    logic      take;

    assign push = tl_v_reg[TILE_BITS] && en;
    assign take = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) skid_valid_reg <= 1'b0;
        end else if (push) begin
            if (out_valid_reg && !m_ready) skid_valid_reg <= 1'b1;
            else                           out_valid_reg  <= 1'b1;
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) out_reg <= skid_reg;
        end else if (push) begin
            if (out_valid_reg && !m_ready) skid_reg <= res;
            else                           out_reg  <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

@@ src/rptp_checker.sv @@
// Port-level assertions for the pick core, bound to the top level.
module rptp_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input rptp_pkg::rptp_out_t m_data
);
    import rptp_pkg::*;

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_hit_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.hit == (m_data.reject_cause == CAUSE_HIT)))
        else $error("hit flag disagrees with reject cause");

    a_reject_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> m_data.point_x == REJ_POINT &&
            m_data.point_z == REJ_POINT && m_data.tile_column == '0 &&
            m_data.tile_row == '0)
        else $error("rejected result not filled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("pipeline not empty after reset");

endmodule

bind ray_plane_tile_pick_core rptp_checker u_rptp_checker (.*);
